/* rtl/ilist_pkg.sv */
// Shared types and constants for the indexed list engine.
// Holds the operation and status codes, the beat payload structs and the
// control word that the controller broadcasts to the row of list cells.
package ilist_pkg;

   // Fixed field widths of the beat payloads.
   localparam int DATA_W = 32;
   localparam int POS_W  = 5;
   localparam int CNT_W  = 6;
   localparam int OP_W   = 3;
   localparam int STAT_W = 2;

   // Default store size and the hard ceiling set by the 5-bit positions.
   localparam int CAPACITY_DEFAULT = 32;
   localparam int LIST_MAX         = 32;

   // Operation codes carried in the request beat.
   typedef enum logic [OP_W-1:0] {
      OP_INIT   = 3'd0,
      OP_PUSH   = 3'd1,
      OP_INSERT = 3'd2,
      OP_REMOVE = 3'd3,
      OP_SWAP   = 3'd4,
      OP_CLEAR  = 3'd5,
      OP_DUMP   = 3'd6
   } op_type;

   // Status codes carried in the response beat.
   typedef enum logic [STAT_W-1:0] {
      STAT_OK     = 2'd0,
      STAT_FULL   = 2'd1,
      STAT_BADPOS = 2'd2,
      STAT_EMPTY  = 2'd3
   } status_type;

   // Controller states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_DUMP,
      S_SWAP
   } state_type;

   // Per-cycle command broadcast to every cell.
   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_INIT,
      CMD_PUSH,
      CMD_INSERT,
      CMD_REMOVE,
      CMD_ROTATE
   } cmd_type;

   // Control word shared by all cells.
   typedef struct packed {
      cmd_type             cmd;
      logic [POS_W-1:0]    pos;
      logic [CNT_W-1:0]    count;
      logic [DATA_W-1:0]   data;
      logic [DATA_W-1:0]   wrap;
   } cell_ctrl_type;

   // Request beat payload.
   typedef struct packed {
      logic [OP_W-1:0]          operation;
      logic [POS_W-1:0]         position;
      logic [POS_W-1:0]         second_position;
      logic signed [DATA_W-1:0] value;
   } req_type;

   // Response beat payload.
   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic signed [DATA_W-1:0] element_value;
      logic [POS_W-1:0]         element_position;
      logic [CNT_W-1:0]         length;
      logic                     last;
   } rsp_type;

endpackage

/* rtl/ilist_cell.sv */
// One element slot of the list, a link in the row of cells.
// Depends on ilist_pkg for the control word; takes data from its left or
// right neighbor, from the broadcast word, or from the wrap-around value.
module ilist_cell import ilist_pkg::*; #(
   parameter int INDEX = 0
) (
   input  logic                clock,
   input  cell_ctrl_type       ctrl,
   input  logic [DATA_W-1:0]   left_value,
   input  logic [DATA_W-1:0]   right_value,
   output logic [DATA_W-1:0]   value
);

   localparam int CW = CNT_W + 1;
   localparam logic [CW-1:0] IDX = CW'(INDEX);

   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] value_in;
   logic [CW-1:0]     cnt;
   logic [CW-1:0]     pos;
   logic [CW-1:0]     pos_next;

   assign cnt      = {1'b0, ctrl.count};
   assign pos      = CW'(ctrl.pos);
   assign pos_next = pos + CW'(1);

   // Choose this cell's next content from the broadcast command.
   always_comb begin
      value_in = value_ff;
      case (ctrl.cmd)
         CMD_INIT: begin
            if (IDX == '0) value_in = ctrl.data;
         end
         CMD_PUSH: begin
            if (IDX == cnt) value_in = ctrl.data;
         end
         CMD_INSERT: begin
            if (IDX == pos_next) value_in = ctrl.data;
            else if (IDX > pos_next && IDX <= cnt) value_in = left_value;
         end
         CMD_REMOVE: begin
            if (IDX >= pos && IDX + CW'(1) < cnt) value_in = right_value;
         end
         CMD_ROTATE: begin
            if (IDX + CW'(1) == cnt) value_in = ctrl.wrap;
            else if (IDX + CW'(1) < cnt) value_in = right_value;
         end
         default: value_in = value_ff;
      endcase
   end

   // Element payload register; no reset needed.
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

/* rtl/indexed_list_engine.sv */
// Indexed list engine top level: a controller driving a row of list cells.
// Depends on ilist_pkg and ilist_cell.
//
// Usage: operations arrive as request beats (req_valid/req_ready/req_data);
// results leave as response beats (rsp_valid/rsp_ready/rsp_data). Every
// operation except dump answers with one beat carrying status and length.
// Init, push, insert, remove and clear complete at the accepting edge: the
// response is registered at that edge and the next request can be taken in
// the following cycle, so these sustain one operation per cycle while the
// receiver takes each response. Dump rotates the cell row one place per
// cycle and emits one beat per element while the receiver is not stalled;
// an empty list gives one beat. Swap rotates the row through two full laps,
// first capturing the two words, then writing them back exchanged, and gives
// its response beat at the end of the second lap. A stalled receiver holds
// the response register; dump and the final swap step wait for it, and no
// request is taken while it is full and stalled.
// Reset empties the list; element storage itself is not cleared, and no
// clearing pass is needed.
module indexed_list_engine import ilist_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int LIMIT = (CAPACITY < LIST_MAX) ? CAPACITY : LIST_MAX;
   localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(LIMIT);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [POS_W-1:0]  step_ff, step_in;
   logic              lap_ff, lap_in;
   logic [POS_W-1:0]  pa_ff, pa_in, pb_ff, pb_in;
   logic [DATA_W-1:0] va_ff, va_in, vb_ff, vb_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   cell_ctrl_type     ctrl;
   logic [DATA_W-1:0] cell_q [LIMIT];
   logic [DATA_W-1:0] head;

   logic out_free, accept, load, full, bad1, bad2, step_last, swap_go, swap_done;

   assign head      = cell_q[0];
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign full      = count_ff >= LIMIT_C;
   assign bad1      = {1'b0, req_data.position} >= count_ff;
   assign bad2      = {1'b0, req_data.second_position} >= count_ff;
   assign step_last = {1'b0, step_ff} == count_ff - CNT_W'(1);
   assign swap_done = (state_ff == S_SWAP) && lap_ff && step_last;
   assign swap_go   = (state_ff == S_SWAP) && (!swap_done || out_free);

   // Row of list cells, each passing its word to a neighbor.
   for (genvar i = 0; i < LIMIT; i++) begin : g_cell
      logic [DATA_W-1:0] left_v, right_v;
      if (i == 0) begin : g_lo
         assign left_v = '0;
      end else begin : g_lo
         assign left_v = cell_q[i-1];
      end
      if (i == LIMIT - 1) begin : g_hi
         assign right_v = '0;
      end else begin : g_hi
         assign right_v = cell_q[i+1];
      end
      ilist_cell #(.INDEX(i)) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .left_value  (left_v),
         .right_value (right_v),
         .value       (cell_q[i])
      );
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_data.operation == OP_DUMP && count_ff != '0) state_in = S_DUMP;
               else if (req_data.operation == OP_SWAP && !bad1 && !bad2) state_in = S_SWAP;
            end
         end
         S_DUMP: begin
            if (out_free && step_last) state_in = S_IDLE;
         end
         S_SWAP: begin
            if (swap_done && out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Output and datapath logic: cell commands, counters and response beat.
   always_comb begin
      ctrl       = '{cmd: CMD_HOLD, pos: req_data.position, count: count_ff,
                     data: req_data.value, wrap: head};
      count_in   = count_ff;
      step_in    = step_ff;
      lap_in     = lap_ff;
      pa_in      = pa_ff;
      pb_in      = pb_ff;
      va_in      = va_ff;
      vb_in      = vb_ff;
      load       = 1'b0;
      rsp_in     = '{status: STAT_OK, element_value: '0, element_position: '0,
                     length: count_ff, last: 1'b1};
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               load    = 1'b1;
               step_in = '0;
               lap_in  = 1'b0;
               pa_in   = req_data.position;
               pb_in   = req_data.second_position;
               case (op_type'(req_data.operation))
                  OP_INIT: begin
                     ctrl.cmd = CMD_INIT;
                     count_in = CNT_W'(1);
                  end
                  OP_PUSH: begin
                     if (full) begin
                        rsp_in.status = STAT_FULL;
                     end else begin
                        ctrl.cmd = CMD_PUSH;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_INSERT: begin
                     if (bad1) begin
                        rsp_in.status = STAT_BADPOS;
                     end else if (full) begin
                        rsp_in.status = STAT_FULL;
                     end else begin
                        ctrl.cmd = CMD_INSERT;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_REMOVE: begin
                     if (bad1) begin
                        rsp_in.status = STAT_BADPOS;
                     end else begin
                        ctrl.cmd = CMD_REMOVE;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  OP_SWAP: begin
                     if (bad1 || bad2) rsp_in.status = STAT_BADPOS;
                     else load = 1'b0;
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_DUMP: begin
                     if (count_ff == '0) rsp_in.status = STAT_EMPTY;
                     else load = 1'b0;
                  end
                  default: rsp_in.status = STAT_OK;
               endcase
               rsp_in.length = count_in;
            end
         end
         S_DUMP: begin
            if (out_free) begin
               ctrl.cmd                = CMD_ROTATE;
               load                    = 1'b1;
               rsp_in.element_value    = $signed(head);
               rsp_in.element_position = step_ff;
               rsp_in.last             = step_last;
               step_in                 = step_ff + POS_W'(1);
            end
         end
         S_SWAP: begin
            if (swap_go) begin
               ctrl.cmd = CMD_ROTATE;
               // First lap captures both words, second lap writes them back.
               if (!lap_ff) begin
                  if (step_ff == pa_ff) va_in = head;
                  if (step_ff == pb_ff) vb_in = head;
               end else begin
                  if (step_ff == pa_ff) ctrl.wrap = vb_ff;
                  if (step_ff == pb_ff) ctrl.wrap = va_ff;
               end
               if (step_last) begin
                  step_in = '0;
                  lap_in  = 1'b1;
               end else begin
                  step_in = step_ff + POS_W'(1);
               end
               load = swap_done;
            end
         end
         default: load = 1'b0;
      endcase
      rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers and the response beat payload.
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      lap_ff  <= lap_in;
      pa_ff   <= pa_in;
      pb_ff   <= pb_in;
      va_ff   <= va_in;
      vb_ff   <= vb_in;
      if (load) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The list never grows past the usable store size.
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LIMIT_C)
      else $error("list length beyond store size");

   // A beat that is not the last of its operation only comes from a dump.
   a_partial_dump: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.last |-> state_ff == S_DUMP)
      else $error("non-final beat outside dump");

   // A swap in progress never changes the length.
   a_swap_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SWAP |=> $stable(count_ff))
      else $error("length changed during swap");

   // Dumped element positions stay inside the list.
   a_dump_pos: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DUMP |-> {1'b0, step_ff} < count_ff)
      else $error("dump position past list end");

endmodule
